[rtl/core/fsg_pkg.sv]
// shared types, codes and widths of the fire spread grid step unit
package fsg_pkg;

	// field widths
	localparam int ACTION_W = 2;
	localparam int ROW_W = 6;
	localparam int COL_W = 6;
	localparam int CELL_W = 2;
	localparam int COUNT_W = 13;
	localparam int DIM_W = 7;
	localparam int THR_W = 4;
	localparam int NB_W = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 7;

	// grid size defaults
	localparam int DEF_MAX_ROWS = 64;
	localparam int DEF_MAX_COLS = 64;

	// action codes
	localparam logic [ACTION_W-1:0] ACT_WRITE = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ = 2'd2;

	// cell codes
	localparam logic [CELL_W-1:0] CELL_CLEAR = 2'd0;
	localparam logic [CELL_W-1:0] CELL_FIRE = 2'd1;
	localparam logic [CELL_W-1:0] CELL_ASH = 2'd2;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_THR = 2'd2;

	// register reset values
	localparam logic [DIM_W-1:0] ROWS_RST = 7'd64;
	localparam logic [DIM_W-1:0] COLS_RST = 7'd64;
	localparam logic [THR_W-1:0] THR_RST = 4'd2;

	// neighbour offset codes along one axis
	localparam logic [1:0] OFS_LO = 2'd0;
	localparam logic [1:0] OFS_MID = 2'd1;
	localparam logic [1:0] OFS_HI = 2'd2;

	// tag that travels with one grid read of the sweep
	typedef struct packed {
		logic valid;
		logic nb_ok;
		logic is_self;
		logic last;
	} tap_tag_t;

endpackage

[rtl/core/fsg_if.sv]
// handshake channels of the fire spread grid step unit

interface fsg_cmd_if;
	logic valid;
	logic ready;
	logic [fsg_pkg::ACTION_W-1:0] action;
	logic [fsg_pkg::ROW_W-1:0] row;
	logic [fsg_pkg::COL_W-1:0] col;
	logic [fsg_pkg::CELL_W-1:0] cell_state;

	modport source (output valid, output action, output row, output col, output cell_state,
		input ready);
	modport sink (input valid, input action, input row, input col, input cell_state,
		output ready);
endinterface

interface fsg_rsp_if;
	logic valid;
	logic ready;
	logic [fsg_pkg::CELL_W-1:0] cell_value;
	logic [fsg_pkg::COUNT_W-1:0] burning_count;

	modport source (output valid, output cell_value, output burning_count, input ready);
	modport sink (input valid, input cell_value, input burning_count, output ready);
endinterface

interface fsg_cfg_if;
	logic valid;
	logic ready;
	logic [fsg_pkg::CFG_IDX_W-1:0] index;
	logic [fsg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

[rtl/core/fsg_ram.sv]
// generic simple dual port ram with registered read
module fsg_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/core/fsg_eval.sv]
// shared neighbour accumulate and next state unit of the sweep
module fsg_eval #(
	parameter int AW = 12
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         clr_cnt,
	input  fsg_pkg::tap_tag_t            tag,
	input  logic [AW-1:0]                cell_addr,
	input  logic [fsg_pkg::CELL_W-1:0]   rdata,
	input  logic [fsg_pkg::THR_W-1:0]    thr,
	output logic                         nx_we,
	output logic [AW-1:0]                nx_addr,
	output logic [fsg_pkg::CELL_W-1:0]   nx_data,
	output logic [fsg_pkg::COUNT_W-1:0]  count
);

	fsg_pkg::tap_tag_t tag_s1;
	logic [AW-1:0] addr_s1;
	logic [fsg_pkg::NB_W-1:0] acc_q;
	logic [fsg_pkg::CELL_W-1:0] self_q;
	logic [fsg_pkg::COUNT_W-1:0] count_q;
	logic hit;
	logic [fsg_pkg::NB_W-1:0] nb_sum;
	logic [fsg_pkg::CELL_W-1:0] new_val;

	// tag stage lines up with the ram read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1 <= tag;
		end
	end

	always_ff @(posedge clk) begin
		addr_s1 <= cell_addr;
	end

	// neighbour count and generation rule
	always_comb begin
		hit = tag_s1.valid && tag_s1.nb_ok && (rdata == fsg_pkg::CELL_FIRE);
		nb_sum = acc_q + fsg_pkg::NB_W'(hit);
		if (self_q == fsg_pkg::CELL_FIRE) begin
			new_val = fsg_pkg::CELL_ASH;
		end else if (nb_sum >= thr) begin
			new_val = fsg_pkg::CELL_FIRE;
		end else begin
			new_val = self_q;
		end
	end

	assign nx_we = tag_s1.valid && tag_s1.last;
	assign nx_addr = addr_s1;
	assign nx_data = new_val;
	assign count = count_q;

	// accumulator, own cell value and saturating burning count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			self_q <= fsg_pkg::CELL_CLEAR;
			count_q <= '0;
		end else begin
			if (tag_s1.valid) begin
				acc_q <= tag_s1.last ? '0 : nb_sum;
				if (tag_s1.is_self) begin
					self_q <= rdata;
				end
			end
			if (clr_cnt) begin
				count_q <= '0;
			end else if (nx_we && (new_val == fsg_pkg::CELL_FIRE) && (count_q != '1)) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule

[rtl/core/fire_spread_grid_step_unit.sv]
// top level of the fire spread grid step unit
//
//  channel  view    payload                                 taken when
//  cmd      sink    action, row, col, cell_state            valid && ready
//  rsp      source  cell_value, burning_count               valid && ready
//  cfg      sink    index, data (rows, cols, threshold)     valid && ready
//
// a write or unused action replies from idle (through the finish state if the output is busy),
// a read through the read wait and finish states; an advance sweeps the region in use: every
// cell reads its own value and eight neighbours through the one read port of the current grid
// ram, one per cycle into the shared accumulate unit, then copies the next grid back one cell per cycle
// after reset a clearing pass writes all 2**(RW+CW) cells (4096 by default), cmd not ready
// the result sits in an output register; a command is taken while a result waits
module fire_spread_grid_step_unit #(
	parameter int MAX_ROWS = fsg_pkg::DEF_MAX_ROWS,
	parameter int MAX_COLS = fsg_pkg::DEF_MAX_COLS
) (
	input logic clk,
	input logic arst_n,
	fsg_cmd_if.sink cmd,
	fsg_rsp_if.source rsp,
	fsg_cfg_if.sink cfg
);

	localparam int RW = $clog2(MAX_ROWS);
	localparam int CW = $clog2(MAX_COLS);
	localparam int AW = RW + CW;
	localparam int DEPTH = 1 << AW;
	localparam int RCW = $clog2(MAX_ROWS + 1);
	localparam int CCW = $clog2(MAX_COLS + 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_RDW,
		ST_SWEEP,
		ST_DRAIN,
		ST_COPY,
		ST_CDRAIN,
		ST_FIN
	} state_t;

	state_t state_q;
	logic [fsg_pkg::DIM_W-1:0] rows_q;
	logic [fsg_pkg::DIM_W-1:0] cols_q;
	logic [fsg_pkg::THR_W-1:0] thr_q;
	logic [RCW-1:0] nr_q;
	logic [CCW-1:0] nc_q;
	logic [RW-1:0] r_q;
	logic [CW-1:0] c_q;
	logic [1:0] kr_q;
	logic [1:0] kc_q;
	logic [AW-1:0] clr_q;
	logic in_grid_q;
	logic [fsg_pkg::CELL_W-1:0] res_val_q;
	logic [fsg_pkg::COUNT_W-1:0] res_cnt_q;
	logic ov_q;
	logic [fsg_pkg::CELL_W-1:0] ocell_q;
	logic [fsg_pkg::COUNT_W-1:0] ocnt_q;
	logic copy_v_s1;
	logic [AW-1:0] copy_addr_s1;

	logic slot_free;
	logic out_load;
	logic cmd_take;
	logic in_grid;
	logic [AW-1:0] cmd_addr;
	logic [AW-1:0] cell_addr;
	logic [fsg_pkg::CELL_W-1:0] wr_val;
	logic [RCW-1:0] nr_clamp;
	logic [CCW-1:0] nc_clamp;
	logic row_ok;
	logic col_ok;
	logic [RW-1:0] rr;
	logic [CW-1:0] cc;
	logic is_self;
	logic k_last;
	logic c_end;
	logic r_end;
	fsg_pkg::tap_tag_t tag;

	logic cur_we;
	logic [AW-1:0] cur_waddr;
	logic [fsg_pkg::CELL_W-1:0] cur_wdata;
	logic [AW-1:0] cur_raddr;
	logic [fsg_pkg::CELL_W-1:0] cur_rdata;
	logic nx_we;
	logic [AW-1:0] nx_waddr;
	logic [fsg_pkg::CELL_W-1:0] nx_wdata;
	logic [fsg_pkg::CELL_W-1:0] nx_rdata;
	logic [fsg_pkg::COUNT_W-1:0] fire_count;

	// handshakes
	assign slot_free = !ov_q || rsp.ready;
	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_take = cmd.valid && cmd.ready;
	assign cfg.ready = 1'b1;
	assign rsp.valid = ov_q;
	assign rsp.cell_value = ocell_q;
	assign rsp.burning_count = ocnt_q;

	// output register takes a new word this cycle
	assign out_load = slot_free && ((state_q == ST_FIN) || ((state_q == ST_IDLE) && cmd.valid
		&& (cmd.action != fsg_pkg::ACT_READ) && (cmd.action != fsg_pkg::ACT_ADVANCE)));

	// command address and write value
	always_comb begin
		in_grid = (int'(cmd.row) < MAX_ROWS) && (int'(cmd.col) < MAX_COLS);
		cmd_addr = {RW'(cmd.row), CW'(cmd.col)};
		case (cmd.cell_state)
			fsg_pkg::CELL_CLEAR: wr_val = fsg_pkg::CELL_CLEAR;
			fsg_pkg::CELL_FIRE: wr_val = fsg_pkg::CELL_FIRE;
			default: wr_val = fsg_pkg::CELL_ASH;
		endcase
	end

	// region size clamped to the grid
	always_comb begin
		if (rows_q == '0) begin
			nr_clamp = RCW'(1);
		end else if (int'(rows_q) > MAX_ROWS) begin
			nr_clamp = RCW'(MAX_ROWS);
		end else begin
			nr_clamp = RCW'(rows_q);
		end
		if (cols_q == '0) begin
			nc_clamp = CCW'(1);
		end else if (int'(cols_q) > MAX_COLS) begin
			nc_clamp = CCW'(MAX_COLS);
		end else begin
			nc_clamp = CCW'(cols_q);
		end
	end

	// neighbour address of the current tap
	always_comb begin
		case (kr_q)
			fsg_pkg::OFS_LO: begin
				row_ok = (r_q != '0);
				rr = row_ok ? r_q - 1'b1 : r_q;
			end
			fsg_pkg::OFS_HI: begin
				row_ok = (RCW'(r_q) + RCW'(1)) < nr_q;
				rr = row_ok ? r_q + 1'b1 : r_q;
			end
			default: begin
				row_ok = 1'b1;
				rr = r_q;
			end
		endcase
		case (kc_q)
			fsg_pkg::OFS_LO: begin
				col_ok = (c_q != '0);
				cc = col_ok ? c_q - 1'b1 : c_q;
			end
			fsg_pkg::OFS_HI: begin
				col_ok = (CCW'(c_q) + CCW'(1)) < nc_q;
				cc = col_ok ? c_q + 1'b1 : c_q;
			end
			default: begin
				col_ok = 1'b1;
				cc = c_q;
			end
		endcase
		is_self = (kr_q == fsg_pkg::OFS_MID) && (kc_q == fsg_pkg::OFS_MID);
		k_last = (kr_q == fsg_pkg::OFS_HI) && (kc_q == fsg_pkg::OFS_HI);
		c_end = (CCW'(c_q) + CCW'(1)) == nc_q;
		r_end = (RCW'(r_q) + RCW'(1)) == nr_q;
		cell_addr = {r_q, c_q};
		tag.valid = (state_q == ST_SWEEP);
		tag.nb_ok = row_ok && col_ok && !is_self;
		tag.is_self = is_self;
		tag.last = k_last;
	end

	// current grid port selection
	always_comb begin
		cur_we = 1'b0;
		cur_waddr = cmd_addr;
		cur_wdata = wr_val;
		if (state_q == ST_CLEAR) begin
			cur_we = 1'b1;
			cur_waddr = clr_q;
			cur_wdata = fsg_pkg::CELL_CLEAR;
		end else if (copy_v_s1) begin
			cur_we = 1'b1;
			cur_waddr = copy_addr_s1;
			cur_wdata = nx_rdata;
		end else if (cmd_take && (cmd.action == fsg_pkg::ACT_WRITE) && in_grid) begin
			cur_we = 1'b1;
		end
		cur_raddr = (state_q == ST_SWEEP) ? {rr, cc} : cmd_addr;
	end

	fsg_ram #(
		.WIDTH(fsg_pkg::CELL_W),
		.DEPTH(DEPTH)
	) u_cur_ram (
		.clk(clk),
		.we(cur_we),
		.waddr(cur_waddr),
		.wdata(cur_wdata),
		.raddr(cur_raddr),
		.rdata(cur_rdata)
	);

	fsg_ram #(
		.WIDTH(fsg_pkg::CELL_W),
		.DEPTH(DEPTH)
	) u_nx_ram (
		.clk(clk),
		.we(nx_we),
		.waddr(nx_waddr),
		.wdata(nx_wdata),
		.raddr(cell_addr),
		.rdata(nx_rdata)
	);

	fsg_eval #(
		.AW(AW)
	) u_eval (
		.clk(clk),
		.arst_n(arst_n),
		.clr_cnt(cmd_take && (cmd.action == fsg_pkg::ACT_ADVANCE)),
		.tag(tag),
		.cell_addr(cell_addr),
		.rdata(cur_rdata),
		.thr(thr_q),
		.nx_we(nx_we),
		.nx_addr(nx_waddr),
		.nx_data(nx_wdata),
		.count(fire_count)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= fsg_pkg::ROWS_RST;
			cols_q <= fsg_pkg::COLS_RST;
			thr_q <= fsg_pkg::THR_RST;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				fsg_pkg::REG_ROWS: rows_q <= cfg.data;
				fsg_pkg::REG_COLS: cols_q <= cfg.data;
				fsg_pkg::REG_THR: thr_q <= cfg.data[fsg_pkg::THR_W-1:0];
				default: ;
			endcase
		end
	end

	// copy stage lines up with the next grid read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			copy_v_s1 <= 1'b0;
		end else begin
			copy_v_s1 <= (state_q == ST_COPY);
		end
	end

	always_ff @(posedge clk) begin
		copy_addr_s1 <= cell_addr;
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			nr_q <= '0;
			nc_q <= '0;
			r_q <= '0;
			c_q <= '0;
			kr_q <= fsg_pkg::OFS_LO;
			kc_q <= fsg_pkg::OFS_LO;
			in_grid_q <= 1'b0;
			res_val_q <= fsg_pkg::CELL_CLEAR;
			res_cnt_q <= '0;
			ov_q <= 1'b0;
			ocell_q <= fsg_pkg::CELL_CLEAR;
			ocnt_q <= '0;
		end else begin
			if (ov_q && rsp.ready && !out_load) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (cmd.valid) begin
						case (cmd.action)
							fsg_pkg::ACT_READ: begin
								in_grid_q <= in_grid;
								state_q <= ST_RDW;
							end
							fsg_pkg::ACT_ADVANCE: begin
								nr_q <= nr_clamp;
								nc_q <= nc_clamp;
								r_q <= '0;
								c_q <= '0;
								kr_q <= fsg_pkg::OFS_LO;
								kc_q <= fsg_pkg::OFS_LO;
								state_q <= ST_SWEEP;
							end
							default: begin
								// write and unused code give an all zero word
								res_val_q <= fsg_pkg::CELL_CLEAR;
								res_cnt_q <= '0;
								if (slot_free) begin
									ov_q <= 1'b1;
									ocell_q <= fsg_pkg::CELL_CLEAR;
									ocnt_q <= '0;
								end else begin
									state_q <= ST_FIN;
								end
							end
						endcase
					end
				end
				ST_RDW: begin
					res_val_q <= in_grid_q ? cur_rdata : fsg_pkg::CELL_CLEAR;
					res_cnt_q <= '0;
					state_q <= ST_FIN;
				end
				ST_SWEEP: begin
					if (k_last) begin
						kr_q <= fsg_pkg::OFS_LO;
						kc_q <= fsg_pkg::OFS_LO;
						if (c_end) begin
							c_q <= '0;
							if (r_end) begin
								r_q <= '0;
								state_q <= ST_DRAIN;
							end else begin
								r_q <= r_q + 1'b1;
							end
						end else begin
							c_q <= c_q + 1'b1;
						end
					end else if (kc_q == fsg_pkg::OFS_HI) begin
						kc_q <= fsg_pkg::OFS_LO;
						kr_q <= kr_q + 1'b1;
					end else begin
						kc_q <= kc_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_COPY;
				end
				ST_COPY: begin
					if (c_end) begin
						c_q <= '0;
						if (r_end) begin
							r_q <= '0;
							state_q <= ST_CDRAIN;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_CDRAIN: begin
					res_val_q <= fsg_pkg::CELL_CLEAR;
					res_cnt_q <= fire_count;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (slot_free) begin
						ov_q <= 1'b1;
						ocell_q <= res_val_q;
						ocnt_q <= res_cnt_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

[rtl/core/fsg_checker.sv]
// port level checks of the fire spread grid step unit and their bind
module fsg_checker (
	input logic clk,
	input logic arst_n,
	fsg_cmd_if.sink cmd,
	fsg_rsp_if.source rsp,
	fsg_cfg_if.sink cfg
);

	// a stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.cell_value)
			&& $stable(rsp.burning_count))
		else $error("result word changed while stalled");

	// a word carries a cell or a count, never both
	a_one_field: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.cell_value == fsg_pkg::CELL_CLEAR) || (rsp.burning_count == '0))
		else $error("result word carries both cell and count");

	// no unused cell code is returned
	a_cell_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.cell_value == fsg_pkg::CELL_CLEAR)
			|| (rsp.cell_value == fsg_pkg::CELL_FIRE) || (rsp.cell_value == fsg_pkg::CELL_ASH))
		else $error("unused cell code returned");

	// an advance holds off the next command
	a_adv_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready && (cmd.action == fsg_pkg::ACT_ADVANCE) |=> !cmd.ready)
		else $error("command taken right after an advance");

	// configuration is never held off
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg.valid |-> cfg.ready)
		else $error("configuration write held off");

endmodule

bind fire_spread_grid_step_unit fsg_checker u_fsg_checker (
	.clk(clk),
	.arst_n(arst_n),
	.cmd(cmd),
	.rsp(rsp),
	.cfg(cfg)
);

[dv/fire_spread_grid_step_unit_test.sv]
// testbench of the fire spread grid step unit: directed and random words against a grid predictor
module fire_spread_grid_step_unit_test;

	// codes with no name in the package
	localparam logic [fsg_pkg::ACTION_W-1:0] ACT_SPARE = 2'd3;
	localparam logic [fsg_pkg::CELL_W-1:0] CELL_SPARE = 2'd3;
	localparam int COUNT_CAP = 2 ** fsg_pkg::COUNT_W - 1;
	localparam int STALL_PCT = 21;
	localparam int WATCHDOG_LIMIT = 200000;
	localparam int TAIL_CYCLES = 50;
	localparam int RANDOM_WORDS = 110;

	typedef struct {
		logic [fsg_pkg::CELL_W-1:0] cell_value;
		logic [fsg_pkg::COUNT_W-1:0] burning_count;
	} grid_reply_t;

	logic clk;
	logic arst_n;
	bit calm;
	int errors;
	int words_sent;
	int advances_sent;
	int replies_checked;
	int reg_writes;
	int idle_cycles;

	// predicted grid and registers
	logic [fsg_pkg::CELL_W-1:0] fire_map [fsg_pkg::DEF_MAX_ROWS][fsg_pkg::DEF_MAX_COLS];
	logic [fsg_pkg::DIM_W-1:0] rows_cfg;
	logic [fsg_pkg::DIM_W-1:0] cols_cfg;
	logic [fsg_pkg::THR_W-1:0] thr_cfg;
	grid_reply_t pending_replies [$];

	fsg_cmd_if cmd_ch ();
	fsg_rsp_if rsp_ch ();
	fsg_cfg_if cfg_ch ();

	fire_spread_grid_step_unit i_dut (
		.clk (clk),
		.arst_n (arst_n),
		.cmd (cmd_ch),
		.rsp (rsp_ch),
		.cfg (cfg_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// zero and oversized region values clamp to the legal range
	function automatic int region_size(logic [fsg_pkg::DIM_W-1:0] v, int max_dim);
		if (v == 0) return 1;
		if (int'(v) > max_dim) return max_dim;
		return int'(v);
	endfunction

	// one generation over the region in use, returns the burning count
	function automatic logic [fsg_pkg::COUNT_W-1:0] spread_fire();
		logic [fsg_pkg::CELL_W-1:0] nxt [fsg_pkg::DEF_MAX_ROWS][fsg_pkg::DEF_MAX_COLS];
		int nr;
		int nc;
		int lit;
		int burning;
		int rr;
		int cc;
		nr = region_size(rows_cfg, fsg_pkg::DEF_MAX_ROWS);
		nc = region_size(cols_cfg, fsg_pkg::DEF_MAX_COLS);
		nxt = fire_map;
		burning = 0;
		for (int r = 0; r < nr; r++) begin
			for (int c = 0; c < nc; c++) begin
				lit = 0;
				for (int dr = -1; dr <= 1; dr++) begin
					for (int dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						if ((dr != 0 || dc != 0) && rr >= 0 && cc >= 0 && rr < nr && cc < nc &&
								fire_map[rr][cc] == fsg_pkg::CELL_FIRE)
							lit++;
					end
				end
				if (fire_map[r][c] == fsg_pkg::CELL_FIRE)
					nxt[r][c] = fsg_pkg::CELL_ASH;
				else if (lit >= int'(thr_cfg))
					nxt[r][c] = fsg_pkg::CELL_FIRE;
				if (nxt[r][c] == fsg_pkg::CELL_FIRE)
					burning++;
			end
		end
		fire_map = nxt;
		return (burning > COUNT_CAP) ? fsg_pkg::COUNT_W'(COUNT_CAP) : fsg_pkg::COUNT_W'(burning);
	endfunction

	// apply one accepted command word to the predicted grid
	function automatic grid_reply_t predict_reply(logic [fsg_pkg::ACTION_W-1:0] act,
			logic [fsg_pkg::ROW_W-1:0] row, logic [fsg_pkg::COL_W-1:0] col,
			logic [fsg_pkg::CELL_W-1:0] st);
		grid_reply_t rep;
		rep.cell_value = fsg_pkg::CELL_CLEAR;
		rep.burning_count = '0;
		case (act)
			fsg_pkg::ACT_WRITE: begin
				fire_map[row][col] = (st == CELL_SPARE) ? fsg_pkg::CELL_ASH : st;
			end
			fsg_pkg::ACT_ADVANCE: begin
				rep.burning_count = spread_fire();
			end
			fsg_pkg::ACT_READ: begin
				rep.cell_value = fire_map[row][col];
			end
			default: ;
		endcase
		return rep;
	endfunction

	// send one command word, valid stays up until the next word or a drain
	task automatic send_word(logic [fsg_pkg::ACTION_W-1:0] act, logic [fsg_pkg::ROW_W-1:0] row,
			logic [fsg_pkg::COL_W-1:0] col, logic [fsg_pkg::CELL_W-1:0] st);
		while (!calm && $urandom_range(0, 99) < STALL_PCT) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid <= 1'b1;
		cmd_ch.action <= act;
		cmd_ch.row <= row;
		cmd_ch.col <= col;
		cmd_ch.cell_state <= st;
		@(posedge clk);
		while (!cmd_ch.ready) @(posedge clk);
		pending_replies.push_back(predict_reply(act, row, col, st));
		words_sent++;
		if (act == fsg_pkg::ACT_ADVANCE)
			advances_sent++;
	endtask

	// stop sending and wait until every reply has come back
	task automatic drain_replies();
		cmd_ch.valid <= 1'b0;
		while (pending_replies.size() != 0) @(posedge clk);
	endtask

	// write one register, only called with the block idle
	task automatic write_reg(logic [fsg_pkg::CFG_IDX_W-1:0] idx,
			logic [fsg_pkg::CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= data;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		case (idx)
			fsg_pkg::REG_ROWS: rows_cfg = data;
			fsg_pkg::REG_COLS: cols_cfg = data;
			fsg_pkg::REG_THR: thr_cfg = data[fsg_pkg::THR_W-1:0];
			default: ;
		endcase
		reg_writes++;
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_region(logic [fsg_pkg::CFG_DATA_W-1:0] rows,
			logic [fsg_pkg::CFG_DATA_W-1:0] cols, logic [fsg_pkg::CFG_DATA_W-1:0] thr);
		drain_replies();
		write_reg(fsg_pkg::REG_ROWS, rows);
		write_reg(fsg_pkg::REG_COLS, cols);
		write_reg(fsg_pkg::REG_THR, thr);
	endtask

	// cells clear after reset, full grid advance on reset registers
	task automatic test_reset_state();
		send_word(fsg_pkg::ACT_READ, 6'd0, 6'd0, fsg_pkg::CELL_CLEAR);
		send_word(fsg_pkg::ACT_READ, 6'd63, 6'd63, fsg_pkg::CELL_CLEAR);
		send_word(fsg_pkg::ACT_ADVANCE, 6'd0, 6'd0, fsg_pkg::CELL_CLEAR);
	endtask

	// corner and patterned addresses, every cell code including the spare one
	task automatic test_cell_access();
		send_word(fsg_pkg::ACT_WRITE, 6'd0, 6'd0, fsg_pkg::CELL_FIRE);
		send_word(fsg_pkg::ACT_WRITE, 6'd63, 6'd63, fsg_pkg::CELL_ASH);
		send_word(fsg_pkg::ACT_WRITE, 6'd0, 6'd63, CELL_SPARE);
		send_word(fsg_pkg::ACT_WRITE, 6'd63, 6'd0, fsg_pkg::CELL_FIRE);
		send_word(fsg_pkg::ACT_WRITE, 6'd42, 6'd21, fsg_pkg::CELL_FIRE);
		send_word(fsg_pkg::ACT_WRITE, 6'd21, 6'd42, fsg_pkg::CELL_CLEAR);
		send_word(fsg_pkg::ACT_READ, 6'd0, 6'd63, fsg_pkg::CELL_CLEAR);
		send_word(fsg_pkg::ACT_READ, 6'd63, 6'd63, CELL_SPARE);
		send_word(fsg_pkg::ACT_READ, 6'd42, 6'd21, fsg_pkg::CELL_CLEAR);
	endtask

	// the spare action leaves the grid alone and replies with zeros
	task automatic test_spare_action();
		send_word(ACT_SPARE, 6'd63, 6'd63, CELL_SPARE);
		send_word(fsg_pkg::ACT_READ, 6'd63, 6'd63, fsg_pkg::CELL_CLEAR);
	endtask

	// zero region acts as one cell, oversized region as the whole grid
	task automatic test_region_limits();
		set_region(7'd0, 7'd0, 7'd2);
		send_word(fsg_pkg::ACT_ADVANCE, 6'd0, 6'd0, fsg_pkg::CELL_CLEAR);
		send_word(fsg_pkg::ACT_WRITE, 6'd5, 6'd5, fsg_pkg::CELL_FIRE);
		send_word(fsg_pkg::ACT_READ, 6'd5, 6'd5, fsg_pkg::CELL_CLEAR);
		set_region(7'd127, 7'd127, 7'd1);
		send_word(fsg_pkg::ACT_ADVANCE, 6'd0, 6'd0, fsg_pkg::CELL_CLEAR);
	endtask

	// threshold zero ignites everything, above eight never ignites
	task automatic test_threshold_limits();
		set_region(7'd3, 7'd3, 7'd0);
		send_word(fsg_pkg::ACT_ADVANCE, 6'd0, 6'd0, fsg_pkg::CELL_CLEAR);
		send_word(fsg_pkg::ACT_ADVANCE, 6'd0, 6'd0, fsg_pkg::CELL_CLEAR);
		set_region(7'd3, 7'd3, 7'd15);
		send_word(fsg_pkg::ACT_ADVANCE, 6'd0, 6'd0, fsg_pkg::CELL_CLEAR);
		set_region(7'd3, 7'd3, 7'd8);
		send_word(fsg_pkg::ACT_ADVANCE, 6'd0, 6'd0, fsg_pkg::CELL_CLEAR);
	endtask

	// random regions seeded with fire, then advanced and probed
	task automatic test_random_fire();
		int counted;
		int episode;
		int burst;
		int pick;
		int nr;
		int nc;
		logic [fsg_pkg::CFG_DATA_W-1:0] rows;
		logic [fsg_pkg::CFG_DATA_W-1:0] cols;
		logic [fsg_pkg::CFG_DATA_W-1:0] thr;
		counted = 0;
		episode = 0;
		while (counted < RANDOM_WORDS) begin
			rows = ($urandom_range(0, 9) == 0) ? fsg_pkg::CFG_DATA_W'($urandom_range(9, 32))
				: fsg_pkg::CFG_DATA_W'($urandom_range(1, 8));
			cols = ($urandom_range(0, 9) == 0) ? fsg_pkg::CFG_DATA_W'($urandom_range(9, 32))
				: fsg_pkg::CFG_DATA_W'($urandom_range(1, 8));
			if ($urandom_range(0, 19) == 0)
				rows = $urandom_range(0, 1) ? 7'd0 : 7'd127;
			thr = ($urandom_range(0, 3) == 0) ? fsg_pkg::CFG_DATA_W'($urandom_range(0, 15))
				: fsg_pkg::CFG_DATA_W'($urandom_range(1, 3));
			set_region(rows, cols, thr);
			// one whole episode without any idling on either side
			calm = (episode == 3);
			nr = region_size(rows_cfg, fsg_pkg::DEF_MAX_ROWS);
			nc = region_size(cols_cfg, fsg_pkg::DEF_MAX_COLS);
			burst = $urandom_range(6, 16);
			for (int i = 0; i < burst; i++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45) begin
					send_word(fsg_pkg::ACT_WRITE, fsg_pkg::ROW_W'($urandom_range(0, nr - 1)),
						fsg_pkg::COL_W'($urandom_range(0, nc - 1)),
						fsg_pkg::CELL_W'($urandom_range(0, 3)));
				end else if (pick < 55) begin
					send_word(fsg_pkg::ACT_WRITE, fsg_pkg::ROW_W'($urandom_range(0, 63)),
						fsg_pkg::COL_W'($urandom_range(0, 63)),
						fsg_pkg::CELL_W'($urandom_range(0, 3)));
				end else if (pick < 75) begin
					send_word(fsg_pkg::ACT_ADVANCE, fsg_pkg::ROW_W'($urandom_range(0, 63)),
						fsg_pkg::COL_W'($urandom_range(0, 63)),
						fsg_pkg::CELL_W'($urandom_range(0, 3)));
				end else if (pick < 95) begin
					if ($urandom_range(0, 1))
						send_word(fsg_pkg::ACT_READ, fsg_pkg::ROW_W'($urandom_range(0, nr - 1)),
							fsg_pkg::COL_W'($urandom_range(0, nc - 1)),
							fsg_pkg::CELL_W'($urandom_range(0, 3)));
					else
						send_word(fsg_pkg::ACT_READ, fsg_pkg::ROW_W'($urandom_range(0, 63)),
							fsg_pkg::COL_W'($urandom_range(0, 63)),
							fsg_pkg::CELL_W'($urandom_range(0, 3)));
				end else begin
					send_word(ACT_SPARE, fsg_pkg::ROW_W'($urandom_range(0, 63)),
						fsg_pkg::COL_W'($urandom_range(0, 63)),
						fsg_pkg::CELL_W'($urandom_range(0, 3)));
					counted--;
				end
				counted++;
			end
			calm = 1'b0;
			episode++;
		end
	endtask

	// reply checker and receiver stalls
	initial begin
		grid_reply_t want;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (pending_replies.size() == 0) begin
					$display("%0t: unexpected reply cell_value %0d burning_count %0d", $time,
						rsp_ch.cell_value, rsp_ch.burning_count);
					errors++;
				end else begin
					want = pending_replies.pop_front();
					replies_checked++;
					if (rsp_ch.cell_value !== want.cell_value) begin
						$display("%0t: cell_value expected %0d actual %0d", $time,
							want.cell_value, rsp_ch.cell_value);
						errors++;
					end
					if (rsp_ch.burning_count !== want.burning_count) begin
						$display("%0t: burning_count expected %0d actual %0d", $time,
							want.burning_count, rsp_ch.burning_count);
						errors++;
					end
				end
			end
			rsp_ch.ready <= calm || ($urandom_range(0, 99) >= STALL_PCT);
		end
	end

	// watchdog on cycles with no word moving on any channel
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
					(cfg_ch.valid && cfg_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("%0t: no progress for %0d cycles", $time, idle_cycles);
				$display("Some tests failed");
				$finish;
			end
		end
	end

	// main sequence
	initial begin
		errors = 0;
		words_sent = 0;
		advances_sent = 0;
		replies_checked = 0;
		reg_writes = 0;
		calm = 1'b0;
		rows_cfg = fsg_pkg::ROWS_RST;
		cols_cfg = fsg_pkg::COLS_RST;
		thr_cfg = fsg_pkg::THR_RST;
		for (int r = 0; r < fsg_pkg::DEF_MAX_ROWS; r++)
			for (int c = 0; c < fsg_pkg::DEF_MAX_COLS; c++)
				fire_map[r][c] = fsg_pkg::CELL_CLEAR;
		arst_n = 1'b0;
		cmd_ch.valid = 1'b0;
		cmd_ch.action = fsg_pkg::ACT_WRITE;
		cmd_ch.row = '0;
		cmd_ch.col = '0;
		cmd_ch.cell_state = fsg_pkg::CELL_CLEAR;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = fsg_pkg::REG_ROWS;
		cfg_ch.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_cell_access();
		test_spare_action();
		test_region_limits();
		test_threshold_limits();
		test_random_fire();

		drain_replies();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("run covered %0d command words, %0d of them advances, and %0d register writes",
			words_sent, advances_sent, reg_writes);
		$display("%0d replies checked against the predicted grid", replies_checked);
		if (errors == 0 && pending_replies.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
